[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_AT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Data width, operation and status codes, and the cell link types.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned DataW = 32;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncDelete = 1'b1;

  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StOverflow = 2'd1;
  localparam logic [1:0] StEmpty    = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  // Broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [DataW-1:0] value;
  } spq_cmd_t;

  // What one cell shows its neighbors
  typedef struct packed {
    logic                    vld;
    logic signed [DataW-1:0] data;
    logic                    keep;
    logic                    hit;
  } spq_link_t;

endpackage

`default_nettype wire

[design/spq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot: holds, takes the new value, or shifts from a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::spq_cmd_t   cmd_i,
  input  spq_pkg::spq_link_t  prev_i,
  input  spq_pkg::spq_link_t  next_i,
  output spq_pkg::spq_link_t  link_o
);
  import spq_pkg::*;

  logic                    vld_q, vld_d;
  logic signed [DataW-1:0] data_q, data_d;
  logic                    keep, found, hit;

  assign keep  = vld_q && (cmd_i.value < data_q);
  assign found = vld_q && (cmd_i.value == data_q);
  assign hit   = prev_i.hit || found;

  always_comb begin
    vld_d  = vld_q;
    data_d = data_q;
    priority if (cmd_i.ins) begin
      priority if (keep) begin
        vld_d  = vld_q;
        data_d = data_q;
      end else if (prev_i.keep) begin
        vld_d  = 1'b1;
        data_d = cmd_i.value;
      end else begin
        vld_d  = prev_i.vld;
        data_d = prev_i.data;
      end
    end else if (cmd_i.del && hit) begin
      vld_d  = next_i.vld;
      data_d = next_i.data;
    end else begin
      vld_d  = vld_q;
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign link_o = '{vld: vld_q, data: data_q, keep: keep, hit: hit};

endmodule

`default_nettype wire

[design/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue
// Up to DEPTH signed values kept in descending order in a row of cells.
// ----------------------------------------------------------------------------
// The queue takes one item in every cycle: busy_o stays low. func_i selects
// insert (placed ahead of equal values) or delete (first equal value). Every
// item gives one result, on done_o in the cycle after it is taken, with the
// status, the largest value held and the count; the receiver cannot stall it.
// Each cell compares against the item's value at once, so no item waits on the last;
// a delete's match ripples through all DEPTH cells, which sets the clock period.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              func_i,
  input  logic signed [spq_pkg::DataW-1:0]  value_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic signed [spq_pkg::DataW-1:0]  top_value_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  localparam spq_link_t HeadLink = '{vld: 1'b0, data: '0, keep: 1'b1, hit: 1'b0};
  localparam spq_link_t TailLink = '{vld: 1'b0, data: '0, keep: 1'b0, hit: 1'b0};

  logic            accept, full, empty, found;
  spq_cmd_t        cmd;
  spq_link_t       link [DEPTH];
  logic [CntW-1:0] fill_q, fill_d;
  logic [1:0]      status_q, status_d;
  logic            done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (fill_q == CntW'(DEPTH));
  assign empty  = (fill_q == '0);
  assign found  = link[DEPTH-1].hit;

  assign cmd.ins   = accept && (func_i == FuncInsert) && !full;
  assign cmd.del   = accept && (func_i == FuncDelete);
  assign cmd.value = value_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_link_t prev_l, next_l;
    if (i == 0) begin : g_head
      assign prev_l = HeadLink;
    end else begin : g_mid
      assign prev_l = link[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_l = TailLink;
    end else begin : g_body
      assign next_l = link[i+1];
    end
    spq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .prev_i (prev_l),
      .next_i (next_l),
      .link_o (link[i])
    );
  end

  always_comb begin
    fill_d   = fill_q;
    status_d = StDone;
    unique case (func_i)
      FuncInsert: begin
        if (full) begin
          status_d = StOverflow;
        end else begin
          fill_d = fill_q + CntW'(1);
        end
      end
      FuncDelete: begin
        priority if (empty) begin
          status_d = StEmpty;
        end else if (!found) begin
          status_d = StNotFound;
        end else begin
          fill_d = fill_q - CntW'(1);
        end
      end
      default: status_d = StDone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign top_value_o = link[0].vld ? link[0].data : '0;
  assign count_o     = fill_q;

endmodule

`default_nettype wire

[design/spq_checker.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level checks on result timing, status, count and top value.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spq_assert #(
  parameter int unsigned DEPTH = 8
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              done_o,
  input logic [1:0]                        status_o,
  input logic signed [spq_pkg::DataW-1:0]  top_value_o,
  input logic [$clog2(DEPTH+1)-1:0]        count_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  `ASSERT_NEXT(a_result_follows, start_i && !busy_o, done_o)
  `ASSERT_AT(a_no_spurious_result, done_o |-> $past(start_i && !busy_o))
  `ASSERT_AT(a_overflow_full, (done_o && status_o == StOverflow) |-> count_o == CntW'(DEPTH))
  `ASSERT_AT(a_empty_zero, (done_o && status_o == StEmpty) |-> (count_o == '0 && top_value_o == '0))
  `ASSERT_AT(a_count_bound, count_o <= CntW'(DEPTH))

endmodule

bind sorted_priority_queue spq_assert #(.DEPTH(DEPTH)) u_spq_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .status_o    (status_o),
  .top_value_o (top_value_o),
  .count_o     (count_o)
);

`default_nettype wire
